@@ sv/sspg_pkg.sv @@
// shared constants and control types for the stepper step pulse generator
`timescale 1ns / 1ps
package sspg_pkg;

  // timer ticks per second at full rate
  localparam int MAX_RATE = 10000;
  // quotient width and iteration counter width of the interval divider
  localparam int QW  = $clog2(MAX_RATE + 1);
  localparam int QCW = $clog2(QW);

  localparam int CFG_W  = 10;
  localparam int POS_W  = 16;
  localparam int STEP_W = 23;
  localparam int TC_W   = 16;
  localparam int PROD_W = POS_W + CFG_W;
  localparam int DIV_W  = 2 * CFG_W;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  // item kinds
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ABS  = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_STEPS_PER_MM = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED        = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REVERSE      = 2'd2;

  localparam logic [CFG_W-1:0] STEPS_PER_MM_RST = 10'd80;
  localparam logic [CFG_W-1:0] SPEED_RST        = 10'd10;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic commit;
  } sspg_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sspg_sts_t;

endpackage

@@ sv/stepper_step_pulse_generator.sv @@
// top level of the stepper step/direction pulse generator
`timescale 1ns / 1ps
// Step/direction generator for a stepper driver. Each request on the input
// stream is a tick from the step timer or a move (absolute target or relative
// offset, in 1/16 mm), and each yields exactly one result with the step pulse,
// direction level, moving flag, wake flag and the signed steps still to go.
// A request holds the block until its result is committed to the output
// register. For a tick that has steps pending at nonzero speed and nonzero
// steps_per_mm, the step interval
// MAX_RATE / (speed * steps_per_mm) comes from a restoring divider that
// produces one quotient bit per cycle, and a move's step count comes from
// one 16x10 multiply. One request is in work at a time; the result
// sits in an output register, so the next request is taken while the
// previous result still waits. Configuration writes belong in idle periods.
module stepper_step_pulse_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sspg_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] distance_mm
  input  logic [sspg_pkg::IN_USER_W-1:0]      in_tuser,   // [1:0] mode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sspg_pkg::OUT_DATA_W-1:0]     out_tdata,  // [0] step_pulse, [1] dir_level,
                                                          // [2] moving, [3] wake,
                                                          // [26:4] remaining_steps, rest zero
  // register writes: 0 steps_per_mm, 1 speed_mm_per_s, 2 motor_reverse
  input  logic                                cfg_wen,
  input  logic [sspg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sspg_pkg::CFG_W-1:0]          cfg_wdata
);
  import sspg_pkg::*;

  sspg_cmd_t cmd;
  sspg_sts_t sts;

  // sequencer: accept, multiply, divide, commit
  sspg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, motion state and arithmetic
  sspg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ sv/sspg_ctrl.sv @@
// sequencing state machine for the stepper step pulse generator
`timescale 1ns / 1ps
module sspg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sspg_pkg::sspg_sts_t sts,
  output sspg_pkg::sspg_cmd_t cmd
);
  import sspg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        cmd.div_init = 1'b1;
        state_nxt    = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the result slot before committing
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/sspg_dp.sv @@
// datapath of the stepper step pulse generator: config, motion state, multiplier, divider
`timescale 1ns / 1ps
module sspg_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [sspg_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [sspg_pkg::IN_USER_W-1:0]       in_tuser,
  input  logic                                 cfg_wen,
  input  logic [sspg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sspg_pkg::CFG_W-1:0]           cfg_wdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sspg_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  sspg_pkg::sspg_cmd_t                  cmd,
  output sspg_pkg::sspg_sts_t                  sts
);
  import sspg_pkg::*;

  localparam logic [QW-1:0] RATE_BITS = QW'(MAX_RATE);

  // configuration
  logic [CFG_W-1:0] spm_r, speed_r;
  logic             rev_r;

  // motion state
  logic signed [STEP_W-1:0] step_count_r, step_count_nxt;
  logic [TC_W-1:0]          tc_r, tc_nxt;
  logic                     active_r, active_nxt;
  logic signed [POS_W-1:0]  pos_r, pos_nxt;
  logic                     dir_r, dir_nxt;

  // latched request and working registers
  logic [1:0]              mode_r;
  logic signed [POS_W-1:0] dist_r;
  logic [POS_W-1:0]        mag_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DIV_W-1:0]        rem_r;
  logic [QW-1:0]           q_r;
  logic [QCW-1:0]          cnt_r;

  // result register
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    pulse_nxt, wake_nxt;

  // difference to the target, or the relative offset, 17 bit
  logic signed [POS_W:0] diff;
  logic [POS_W:0]        diff_abs;
  logic [POS_W-1:0]      mul_a;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W:0]        rem_sub;
  logic signed [POS_W:0] pos_sum;
  logic signed [POS_W-1:0] pos_sat;
  logic [STEP_W-1:0]     step_mag;
  logic signed [STEP_W-1:0] step_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r   <= STEPS_PER_MM_RST;
      speed_r <= SPEED_RST;
      rev_r   <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_STEPS_PER_MM: spm_r   <= cfg_wdata;
        REG_SPEED:        speed_r <= cfg_wdata;
        REG_REVERSE:      rev_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign diff = (in_tuser == MODE_ABS)
              ? ($signed({in_tdata[POS_W-1], in_tdata}) - $signed({pos_r[POS_W-1], pos_r}))
              : $signed({in_tdata[POS_W-1], in_tdata});
  assign diff_abs = diff[POS_W] ? (POS_W+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      dist_r <= $signed(in_tdata);
      mag_r  <= diff_abs[POS_W-1:0];
      neg_r  <= diff[POS_W];
    end
  end

  // one multiplier: step interval rate on ticks, step distance on moves
  assign mul_a = (mode_r == MODE_TICK) ? POS_W'(speed_r) : mag_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(spm_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_r, RATE_BITS[cnt_r]};
  assign rem_sub = rem_sh - {1'b0, prod_r[DIV_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= QCW'(QW - 1);
    end else if (cmd.div_step) begin
      if (!rem_sub[DIV_W]) begin
        rem_r <= rem_sub[DIV_W-1:0];
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DIV_W-1:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign sts.need_div = (mode_r == MODE_TICK) && (step_count_r != '0)
                        && (spm_r != '0) && (speed_r != '0);
  assign sts.div_last = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  // new step count of a move, truncated toward zero
  assign step_mag = STEP_W'(prod_r[PROD_W-1:4]);
  assign step_new = (neg_r ^ rev_r) ? -$signed(step_mag) : $signed(step_mag);

  assign pos_sum = $signed({pos_r[POS_W-1], pos_r}) + $signed({dist_r[POS_W-1], dist_r});
  always_comb begin
    if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
      pos_sat = pos_sum[POS_W] ? $signed({1'b1, {(POS_W-1){1'b0}}})
                               : $signed({1'b0, {(POS_W-1){1'b1}}});
    end else begin
      pos_sat = pos_sum[POS_W-1:0];
    end
  end

  always_comb begin
    step_count_nxt = step_count_r;
    tc_nxt         = tc_r;
    active_nxt     = active_r;
    pos_nxt        = pos_r;
    dir_nxt        = dir_r;
    pulse_nxt      = 1'b0;
    wake_nxt       = 1'b0;
    case (mode_r)
      MODE_TICK: begin
        if (step_count_r == '0) begin
          active_nxt = 1'b0;
        end else if (sts.need_div) begin
          if (tc_r < TC_W'(q_r)) begin
            tc_nxt = tc_r + 1'b1;
          end else begin
            tc_nxt    = '0;
            pulse_nxt = 1'b1;
            if (!step_count_r[STEP_W-1]) begin
              dir_nxt        = 1'b1;
              step_count_nxt = step_count_r - 1'b1;
            end else begin
              dir_nxt        = 1'b0;
              step_count_nxt = step_count_r + 1'b1;
            end
          end
        end
      end
      MODE_ABS: begin
        step_count_nxt = step_new;
        pos_nxt        = dist_r;
        active_nxt     = 1'b1;
        wake_nxt       = 1'b1;
      end
      MODE_REL: begin
        if (dist_r != '0) begin
          step_count_nxt = step_new;
          pos_nxt        = pos_sat;
          active_nxt     = 1'b1;
          wake_nxt       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      tc_r         <= '0;
      active_r     <= 1'b0;
      pos_r        <= '0;
      dir_r        <= 1'b0;
    end else if (cmd.commit) begin
      step_count_r <= step_count_nxt;
      tc_r         <= tc_nxt;
      active_r     <= active_nxt;
      pos_r        <= pos_nxt;
      dir_r        <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= OUT_DATA_W'({step_count_nxt, wake_nxt, active_nxt, dir_nxt, pulse_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ tb/tb_stepper_step_pulse_generator.sv @@
// self-checking testbench for the stepper step pulse generator
`timescale 1ns / 1ps
module tb_stepper_step_pulse_generator;
  import sspg_pkg::*;

  // the block ignores this kind of request
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // more than the slowest request takes from acceptance to result
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 125;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] distance;
  } step_req_t;

  // lowest bit last, matching the result data layout
  typedef struct packed {
    logic [22:0] remaining;
    logic        wake;
    logic        moving;
    logic        dir;
    logic        pulse;
  } step_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;   // [15:0] distance_mm
  logic [IN_USER_W-1:0]   in_tuser = '0;   // [1:0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;       // [0] step_pulse, [1] dir_level, [2] moving,
                                           // [3] wake, [26:4] remaining_steps, rest zero
  logic                   cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  stepper_step_pulse_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies, kept in step with every write
  logic [CFG_W-1:0] cfg_spm   = STEPS_PER_MM_RST;
  logic [CFG_W-1:0] cfg_speed = SPEED_RST;
  logic             cfg_rev   = 1'b0;

  // motion state as the block should hold it
  logic signed [22:0] st_count  = '0;
  logic [15:0]        st_ticks  = '0;
  logic               st_moving = 1'b0;
  logic signed [15:0] st_pos    = '0;
  logic               st_dir    = 1'b0;

  step_req_t    pending_reqs[$];
  step_result_t expected_results[$];

  int fail_count   = 0;
  int req_accepted = 0;
  int phase_items  = 0;
  int gen_pos      = 0;   // position after every queued request
  logic hold_out   = 1'b0;

  // signed step count for an offset in 1/16 mm: truncate toward zero, then reverse
  function automatic logic [22:0] steps_for_offset(int d);
    longint unsigned mag;
    longint s;
    mag = (d < 0) ? -d : d;
    s = longint'((mag * cfg_spm) >> 4);
    if (d < 0) s = -s;
    if (cfg_rev) s = -s;
    return s[22:0];
  endfunction

  // advance the motion state by one request and return what the block reports
  function automatic step_result_t predict_step_result(step_req_t r);
    step_result_t res;
    int unsigned rate;
    int unsigned interval;
    int p;
    res = '0;
    case (r.mode)
      MODE_TICK: begin
        if (st_count == 0) begin
          // nothing left, the move is over
          st_moving = 1'b0;
        end else begin
          rate = cfg_speed * cfg_spm;
          // zero rate freezes the tick counter and the move
          if (rate != 0) begin
            interval = MAX_RATE / rate;
            if (st_ticks < interval) begin
              st_ticks = st_ticks + 16'd1;
            end else begin
              st_ticks = '0;
              if (st_count > 0) begin
                st_dir = 1'b1;
                st_count = st_count - 23'sd1;
              end else begin
                st_dir = 1'b0;
                st_count = st_count + 23'sd1;
              end
              res.pulse = 1'b1;
            end
          end
        end
      end
      MODE_ABS: begin
        st_count = steps_for_offset(int'(r.distance) - int'(st_pos));
        st_pos = r.distance;
        st_moving = 1'b1;
        res.wake = 1'b1;
      end
      MODE_REL: begin
        // a zero offset changes nothing and does not wake the driver
        if (r.distance != 0) begin
          p = int'(st_pos) + int'(r.distance);
          if (p > 32767) p = 32767;
          if (p < -32768) p = -32768;
          st_count = steps_for_offset(int'(r.distance));
          st_pos = p[15:0];
          st_moving = 1'b1;
          res.wake = 1'b1;
        end
      end
      default: ;
    endcase
    res.dir = st_dir;
    res.moving = st_moving;
    res.remaining = st_count;
    return res;
  endfunction

  // queue one request and follow the position it leaves behind
  function automatic void queue_req(logic [1:0] mode, logic signed [15:0] distance);
    int p;
    step_req_t r;
    r.mode = mode;
    r.distance = distance;
    pending_reqs.push_back(r);
    if (mode == MODE_ABS) begin
      gen_pos = int'(distance);
    end else if (mode == MODE_REL) begin
      p = gen_pos + int'(distance);
      gen_pos = (p > 32767) ? 32767 : ((p < -32768) ? -32768 : p);
    end
    // ignored kinds and empty offsets do not count toward the phase
    if (mode == MODE_TICK || mode == MODE_ABS || (mode == MODE_REL && distance != 0))
      phase_items++;
  endfunction

  // ticks carry random distance bits, which the block must ignore
  function automatic void queue_ticks(int n);
    for (int i = 0; i < n; i++) queue_req(MODE_TICK, 16'($urandom));
  endfunction

  // register write while the block is idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_STEPS_PER_MM: cfg_spm = data;
      REG_SPEED:        cfg_speed = data;
      REG_REVERSE:      cfg_rev = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // sampled between edges so the queues and the valid have settled
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly short moves followed by enough ticks to finish them, some large
  // moves that get cut off, and a little noise
  task automatic run_random_phase();
    int kind;
    int delta;
    int dmax;
    int nsteps;
    int rate;
    int est;
    int target;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        case ($urandom_range(0, 2))
          0: queue_req(MODE_UNUSED, 16'($urandom));
          1: queue_req(MODE_REL, 16'sd0);
          default: queue_ticks(1);
        endcase
      end else if (kind < 22) begin
        queue_req($urandom_range(0, 1) ? MODE_ABS : MODE_REL, 16'($urandom));
        queue_ticks($urandom_range(0, 20));
      end else begin
        // keep the step count small so the move can run down to zero
        dmax = 96 / int'(cfg_spm);
        if (dmax < 1) dmax = 1;
        delta = $urandom_range(1, dmax);
        if ($urandom_range(0, 1)) delta = -delta;
        if ($urandom_range(0, 1)) begin
          target = gen_pos + delta;
          if (target > 32767) target = 32767;
          if (target < -32768) target = -32768;
          delta = target - gen_pos;
          queue_req(MODE_ABS, target[15:0]);
        end else begin
          queue_req(MODE_REL, delta[15:0]);
        end
        nsteps = ((delta < 0 ? -delta : delta) * int'(cfg_spm)) / 16;
        rate = int'(cfg_speed) * int'(cfg_spm);
        if (rate == 0) est = $urandom_range(1, 8);
        else est = nsteps * (MAX_RATE / rate + 1) + $urandom_range(1, 4);
        if (est > 160) est = 160;
        // sometimes a new move lands in the middle of the old one
        if ($urandom_range(0, 3) == 0) est = $urandom_range(0, est);
        queue_ticks(est);
      end
    end
  endtask

  // request driver: random gap per request, with calm stretches of none
  step_req_t cur_req = '0;
  logic      offering;
  int        send_gap = 0;
  logic      calm_in = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offering = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_step_result(cur_req));
        req_accepted++;
        send_gap = calm_in ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          offering = 1'b1;
        end
      end
      // valid is assigned once per edge, so back-to-back requests keep it high
      in_tvalid <= offering;
      in_tdata  <= cur_req.distance;
      in_tuser  <= cur_req.mode;
    end
  end

  // result monitor: random stall per result plus the long hold-off
  int   recv_wait = 0;
  logic calm_out = 1'b0;

  always @(posedge clk) begin
    step_result_t exp_res;
    step_result_t got_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = out_tdata[26:0];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result %h with nothing outstanding", out_tdata);
        end else begin
          exp_res = expected_results.pop_front();
          if (got_res.pulse !== exp_res.pulse || got_res.dir !== exp_res.dir ||
              got_res.moving !== exp_res.moving || got_res.wake !== exp_res.wake ||
              got_res.remaining !== exp_res.remaining || out_tdata[31:27] !== 5'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp pulse=%0d dir=%0d moving=%0d wake=%0d steps=%0d",
                        " | got pulse=%0d dir=%0d moving=%0d wake=%0d steps=%0d pad=%b"},
                       exp_res.pulse, exp_res.dir, exp_res.moving, exp_res.wake,
                       $signed(exp_res.remaining), got_res.pulse, got_res.dir,
                       got_res.moving, got_res.wake, $signed(got_res.remaining),
                       out_tdata[31:27]);
          end
        end
        recv_wait = calm_out ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0) && !hold_out;
    end
  end

  // long receiver hold-off while requests keep coming, to back up the input
  initial begin
    while (req_accepted < 300) @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  // setting per random phase after the first: steps_per_mm, speed, reverse
  int phase_spm[5]   = '{1, 1023, 3, 8, 40};
  int phase_speed[5] = '{1023, 1023, 0, 700, 125};
  int phase_rev[5]   = '{1, 0, 1, 0, 1};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, interval of twelve ticks
    queue_req(MODE_TICK, 16'hFFFF);         // nothing left, stays idle
    queue_req(MODE_UNUSED, 16'sh8000);      // ignored kind
    queue_req(MODE_REL, 16'sd0);            // empty offset, no wake
    queue_req(MODE_ABS, 16'sd32767);        // top of range
    queue_req(MODE_REL, 16'sd32767);        // position saturates high
    queue_req(MODE_ABS, -16'sd32768);       // widest negative span
    queue_req(MODE_REL, -16'sd32768);       // position saturates low
    queue_req(MODE_ABS, 16'sd0);
    queue_req(MODE_REL, 16'sd1);
    queue_ticks(14);                        // interval runs out, one step
    queue_req(MODE_REL, -16'sd1);           // move reverses
    queue_req(MODE_UNUSED, 16'h7FFF);
    run_random_phase();
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_STEPS_PER_MM, phase_spm[ph][CFG_W-1:0]);
      write_reg(REG_SPEED, phase_speed[ph][CFG_W-1:0]);
      write_reg(REG_REVERSE, phase_rev[ph][CFG_W-1:0]);
      if (ph == 1) begin
        // widest step counts, both signs
        queue_req(MODE_ABS, -16'sd32768);
        queue_req(MODE_ABS, 16'sd32767);
        queue_req(MODE_ABS, -16'sd32768);
      end
      run_random_phase();
      wait_idle();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
